// ----- src/aar_pkg.sv -----
// Shared types and constants of the axis-angle rotation matrix block.
// Holds the CORDIC state that travels down the pipeline and the arctangent table.
// No dependencies.
package aar_pkg;

  // Angle units: 1/128 degree.
  localparam logic [15:0] ONE_TURN     = 16'd46080;
  localparam logic [15:0] QUARTER_TURN = 16'd11520;
  localparam logic [15:0] HALF_TURN    = 16'd23040;
  localparam logic [15:0] THREE_QUARTER_TURN = 16'd34560;

  // One angle unit in radians, Q38.
  localparam logic [39:0] UNIT_TO_RAD_Q38 = 40'd37480660;

  // CORDIC start value: the inverse gain in Q30.
  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  localparam int ATAN_ENTRIES = 24;

  // Width of the exact Q44 sums of the matrix entries.
  localparam int SUM_W = 56;

  // Axis of one item, Q1.14 components.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } axis_t;

  // CORDIC working state of one item, Q30, plus what rides along with it.
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic [1:0]         q;
    axis_t              axis;
  } cordic_t;

  // Nine Q2.14 entries of the result.
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_t;

  // atan(2^-i) in Q30.
  function automatic logic signed [32:0] atan_q30(input logic [4:0] idx);
    logic signed [32:0] a;
    case (idx)
      5'd0:    a = 33'sd843314856;
      5'd1:    a = 33'sd497837829;
      5'd2:    a = 33'sd263043836;
      5'd3:    a = 33'sd133525158;
      5'd4:    a = 33'sd67021686;
      5'd5:    a = 33'sd33543515;
      5'd6:    a = 33'sd16775850;
      5'd7:    a = 33'sd8388437;
      5'd8:    a = 33'sd4194282;
      5'd9:    a = 33'sd2097149;
      5'd10:   a = 33'sd1048575;
      5'd11:   a = 33'sd524287;
      5'd12:   a = 33'sd262143;
      5'd13:   a = 33'sd131071;
      5'd14:   a = 33'sd65535;
      5'd15:   a = 33'sd32767;
      5'd16:   a = 33'sd16383;
      5'd17:   a = 33'sd8191;
      5'd18:   a = 33'sd4095;
      5'd19:   a = 33'sd2047;
      5'd20:   a = 33'sd1023;
      5'd21:   a = 33'sd511;
      5'd22:   a = 33'sd255;
      5'd23:   a = 33'sd127;
      default: a = 33'sd0;
    endcase
    return a;
  endfunction

endpackage

// ----- src/aar_angle.sv -----
// Angle front end: turn reduction, quadrant split and conversion to radians.
// Two register stages; uses aar_pkg for constants and the CORDIC state type.
module aar_angle import aar_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] angle_deg_i,
  input  axis_t       axis_i,
  output logic        valid_o,
  input  logic        ready_i,
  output cordic_t     state_o
);

  logic        v1_q, v2_q;
  logic        go1, go2;
  logic [15:0] u;
  logic [1:0]  q1_d, q1_q;
  logic [13:0] r1_d, r1_q;
  axis_t       axis1_q;
  logic [39:0] rad_prod;
  cordic_t     state_d, state_q;

  // A stage moves when it is empty or its successor moves.
  assign go2     = !v2_q || ready_i;
  assign go1     = !v1_q || go2;
  assign ready_o = go1;

  // Reduce by one turn, then split into quadrant and remainder.
  always_comb begin
    u = (angle_deg_i >= ONE_TURN) ? (angle_deg_i - ONE_TURN) : angle_deg_i;
    if (u >= THREE_QUARTER_TURN) begin
      q1_d = 2'd3;
      r1_d = 14'(u - THREE_QUARTER_TURN);
    end else if (u >= HALF_TURN) begin
      q1_d = 2'd2;
      r1_d = 14'(u - HALF_TURN);
    end else if (u >= QUARTER_TURN) begin
      q1_d = 2'd1;
      r1_d = 14'(u - QUARTER_TURN);
    end else begin
      q1_d = 2'd0;
      r1_d = 14'(u);
    end
  end

  // Remainder to radians in Q30, rounded; the CORDIC starts on the x axis.
  always_comb begin
    rad_prod     = 40'(r1_q) * UNIT_TO_RAD_Q38 + 40'd128;
    state_d.x    = CORDIC_GAIN_Q30;
    state_d.y    = '0;
    state_d.z    = $signed({1'b0, rad_prod[39:8]});
    state_d.q    = q1_q;
    state_d.axis = axis1_q;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (go1) begin
        v1_q <= valid_i;
      end
      if (go2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (go1 && valid_i) begin
      q1_q    <= q1_d;
      r1_q    <= r1_d;
      axis1_q <= axis_i;
    end
    if (go2 && v1_q) begin
      state_q <= state_d;
    end
  end

  assign valid_o = v2_q;
  assign state_o = state_q;

`ifndef NO_ASSERTIONS
  // The remainder always lies inside one quadrant.
  a_rem_in_quadrant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (r1_q < QUARTER_TURN[13:0]))
    else $error("angle remainder outside one quadrant");

  // The CORDIC angle handed on is never negative.
  a_rad_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> !state_q.z[32])
    else $error("negative CORDIC start angle");
`endif

endmodule

// ----- src/aar_cordic_stage.sv -----
// One rotation-mode CORDIC stage with its output register.
// Uses aar_pkg for the state type and the arctangent table.
module aar_cordic_stage import aar_pkg::*; #(
  parameter int STAGE_IDX = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  cordic_t state_i,
  output logic    valid_o,
  input  logic    ready_i,
  output cordic_t state_o
);

  logic               v_q;
  logic               go;
  logic signed [32:0] dx, dy, atan_i;
  cordic_t            state_d, state_q;

  assign go      = !v_q || ready_i;
  assign ready_o = go;

  // Turn toward zero residual angle; shifts round toward minus infinity.
  always_comb begin
    dx      = state_i.y >>> STAGE_IDX;
    dy      = state_i.x >>> STAGE_IDX;
    atan_i  = atan_q30(5'(STAGE_IDX));
    state_d = state_i;
    if (!state_i.z[32]) begin
      state_d.x = state_i.x - dx;
      state_d.y = state_i.y + dy;
      state_d.z = state_i.z - atan_i;
    end else begin
      state_d.x = state_i.x + dx;
      state_d.y = state_i.y - dy;
      state_d.z = state_i.z + atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (go) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = v_q;
  assign state_o = state_q;

endmodule

// ----- src/aar_matrix.sv -----
// Back end: quadrant fold, sine and cosine rounding, products, sums and saturation.
// Five register stages, the last one is the output register; uses aar_pkg types.
module aar_matrix import aar_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  cordic_t state_i,
  output logic    valid_o,
  input  logic    ready_i,
  output mat_t    mat_o
);

  localparam int NUM_STAGES = 5;
  localparam logic signed [SUM_W-1:0] ROUND_Q30 = SUM_W'(536870912);
  localparam logic signed [SUM_W-1:0] ENT_MAX   = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] ENT_MIN   = -SUM_W'(32768);

  logic [NUM_STAGES-1:0] v_q, go;

  // Stage 1: cosine, sine and one minus cosine in Q16.
  logic signed [32:0] cq, sq, c_full, s_full;
  logic signed [18:0] c1_d, s1_d, c1_q, s1_q;
  logic signed [19:0] t1_d, t1_q;
  axis_t              axis1_q;

  // Stage 2: first products.
  logic signed [18:0] c2_q;
  logic signed [35:0] tax_q, tay_q, taz_q;
  logic signed [34:0] sax2_q, say2_q, saz2_q;
  axis_t              axis2_q;

  // Stage 3: second products.
  logic signed [18:0] c3_q;
  logic signed [51:0] txx_q, txy_q, txz_q, tyy_q, tyz_q, tzz_q;
  logic signed [34:0] sax3_q, say3_q, saz3_q;

  // Stage 4: exact Q44 sums.
  logic signed [SUM_W-1:0] diag, shx, shy, shz;
  logic signed [SUM_W-1:0] sum_d [9];
  logic signed [SUM_W-1:0] sum_q [9];

  // Stage 5: output.
  mat_t mat_d, mat_q;

  // Round half up from Q44 to Q14 and clamp to 16 bits.
  function automatic logic signed [15:0] sat_q14(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + ROUND_Q30) >>> 30;
    if (r > ENT_MAX) begin
      return 16'sh7FFF;
    end else if (r < ENT_MIN) begin
      return 16'sh8000;
    end
    return 16'(r);
  endfunction

  // Each stage moves when it is empty or the next one moves.
  always_comb begin
    go[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      go[k] = !v_q[k] || go[k+1];
    end
  end
  assign ready_o = go[0];

  // Fold the quadrant back in and round Q30 to Q16.
  always_comb begin
    case (state_i.q)
      2'd0: begin
        cq = state_i.x;
        sq = state_i.y;
      end
      2'd1: begin
        cq = -state_i.y;
        sq = state_i.x;
      end
      2'd2: begin
        cq = -state_i.x;
        sq = -state_i.y;
      end
      default: begin
        cq = state_i.y;
        sq = -state_i.x;
      end
    endcase
    c_full = (cq + 33'sd8192) >>> 14;
    s_full = (sq + 33'sd8192) >>> 14;
    c1_d   = 19'(c_full);
    s1_d   = 19'(s_full);
    t1_d   = 20'sd65536 - 20'(c1_d);
  end

  // Entry sums; the diagonal adds cosine, the rest add or take sine terms.
  always_comb begin
    diag     = SUM_W'(c3_q) <<< 28;
    shx      = SUM_W'(sax3_q) <<< 14;
    shy      = SUM_W'(say3_q) <<< 14;
    shz      = SUM_W'(saz3_q) <<< 14;
    sum_d[0] = SUM_W'(txx_q) + diag;
    sum_d[1] = SUM_W'(txy_q) - shz;
    sum_d[2] = SUM_W'(txz_q) + shy;
    sum_d[3] = SUM_W'(txy_q) + shz;
    sum_d[4] = SUM_W'(tyy_q) + diag;
    sum_d[5] = SUM_W'(tyz_q) - shx;
    sum_d[6] = SUM_W'(txz_q) - shy;
    sum_d[7] = SUM_W'(tyz_q) + shx;
    sum_d[8] = SUM_W'(tzz_q) + diag;
  end

  always_comb begin
    mat_d.m00 = sat_q14(sum_q[0]);
    mat_d.m01 = sat_q14(sum_q[1]);
    mat_d.m02 = sat_q14(sum_q[2]);
    mat_d.m10 = sat_q14(sum_q[3]);
    mat_d.m11 = sat_q14(sum_q[4]);
    mat_d.m12 = sat_q14(sum_q[5]);
    mat_d.m20 = sat_q14(sum_q[6]);
    mat_d.m21 = sat_q14(sum_q[7]);
    mat_d.m22 = sat_q14(sum_q[8]);
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (go[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (go[0] && valid_i) begin
      c1_q    <= c1_d;
      s1_q    <= s1_d;
      t1_q    <= t1_d;
      axis1_q <= state_i.axis;
    end
    if (go[1] && v_q[0]) begin
      c2_q    <= c1_q;
      tax_q   <= 36'(t1_q) * 36'(axis1_q.x);
      tay_q   <= 36'(t1_q) * 36'(axis1_q.y);
      taz_q   <= 36'(t1_q) * 36'(axis1_q.z);
      sax2_q  <= 35'(s1_q) * 35'(axis1_q.x);
      say2_q  <= 35'(s1_q) * 35'(axis1_q.y);
      saz2_q  <= 35'(s1_q) * 35'(axis1_q.z);
      axis2_q <= axis1_q;
    end
    if (go[2] && v_q[1]) begin
      c3_q   <= c2_q;
      txx_q  <= 52'(tax_q) * 52'(axis2_q.x);
      txy_q  <= 52'(tax_q) * 52'(axis2_q.y);
      txz_q  <= 52'(tax_q) * 52'(axis2_q.z);
      tyy_q  <= 52'(tay_q) * 52'(axis2_q.y);
      tyz_q  <= 52'(tay_q) * 52'(axis2_q.z);
      tzz_q  <= 52'(taz_q) * 52'(axis2_q.z);
      sax3_q <= sax2_q;
      say3_q <= say2_q;
      saz3_q <= saz2_q;
    end
    if (go[3] && v_q[2]) begin
      for (int e = 0; e < 9; e++) begin
        sum_q[e] <= sum_d[e];
      end
    end
    if (go[4] && v_q[3]) begin
      mat_q <= mat_d;
    end
  end

  assign valid_o = v_q[NUM_STAGES-1];
  assign mat_o   = mat_q;

`ifndef NO_ASSERTIONS
  // The CORDIC output keeps unit magnitude, so cosine and sine stay within about one.
  a_cos_sin_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (c1_q <= 19'sd66000 && c1_q >= -19'sd66000 &&
                s1_q <= 19'sd66000 && s1_q >= -19'sd66000))
    else $error("cosine or sine out of range");
`endif

endmodule

// ----- src/axis_angle_rotation_matrix.sv -----
// Axis-angle rotation matrix, top level: angle front end, CORDIC chain, matrix back end.
// Uses aar_pkg, aar_angle, aar_cordic_stage and aar_matrix.
//
// Takes an angle in 1/128 degree units and a Q1.14 axis and returns the nine Q2.14
// entries of the Rodrigues rotation matrix, rounded and saturated. The block is a
// fully pipelined datapath that accepts one item in every cycle while stall_o is low.
// An item passes two register stages for angle reduction and conversion to radians,
// one per unrolled CORDIC stage, and five in the back end (sine and cosine, two
// multiplier levels, sums, saturation). Each stage holds its item under stall and
// empty stages close up, so stall_o rises only when every stage holds an item and
// the output is stalled.
module axis_angle_rotation_matrix import aar_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [15:0]        angle_deg_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o
);

  axis_t                axis_in;
  cordic_t              st [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] vld, rdy;
  logic                 front_ready;
  mat_t                 mat;

  assign axis_in.x = axis_x_i;
  assign axis_in.y = axis_y_i;
  assign axis_in.z = axis_z_i;

  // Angle reduction and conversion.
  aar_angle u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .ready_o     (front_ready),
    .angle_deg_i (angle_deg_i),
    .axis_i      (axis_in),
    .valid_o     (vld[0]),
    .ready_i     (rdy[0]),
    .state_o     (st[0])
  );

  // Unrolled CORDIC, one register stage per iteration.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    aar_cordic_stage #(
      .STAGE_IDX (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .state_i (st[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .state_o (st[i+1])
    );
  end

  // Matrix products, sums and output register.
  aar_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[CORDIC_STAGES]),
    .ready_o (rdy[CORDIC_STAGES]),
    .state_i (st[CORDIC_STAGES]),
    .valid_o (valid_o),
    .ready_i (!stall_i),
    .mat_o   (mat)
  );

  assign stall_o = !front_ready;

  assign m00_o = mat.m00;
  assign m01_o = mat.m01;
  assign m02_o = mat.m02;
  assign m10_o = mat.m10;
  assign m11_o = mat.m11;
  assign m12_o = mat.m12;
  assign m20_o = mat.m20;
  assign m21_o = mat.m21;
  assign m22_o = mat.m22;

`ifndef NO_ASSERTIONS
  // The input side stalls only when the pipeline is full behind a stalled output.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i && (&vld)))
    else $error("input stalled while the pipeline has room");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the axis-angle rotation matrix block.
// Needs only the RTL under src/: aar_pkg and axis_angle_rotation_matrix with its submodules.
// A bit-exact CORDIC/Rodrigues predictor, or a fixed matrix, checks each directed and random item.
`timescale 1ns / 100ps

module testbench;

  // Build of the block and timing of the run.
  localparam int STAGES     = 16;
  localparam int PIPE_LAT   = STAGES + 7;
  localparam int N_DIRECTED = 23;
  localparam int N_RANDOM   = 1880;
  localparam int N_QUIET    = 175;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  // Angle units are 1/128 degree; the CORDIC works in Q30 radians.
  localparam longint TURN_UNITS    = 46080;
  localparam longint QUARTER_UNITS = 11520;
  localparam longint UNIT_RAD_Q38  = 37480660;
  localparam longint CORDIC_K_Q30  = 652032874;
  localparam int     ARCTAN_ROWS   = 24;

  // Nine Q2.14 entries, index 0 is m00 and index 8 is m22.
  typedef logic [0:8][15:0] rot_mat_t;

  localparam logic [15:0] SAT_HI = 16'h7FFF;
  localparam logic [15:0] SAT_LO = 16'h8000;

  // Half turn with an axis far beyond unit length: every entry saturates.
  localparam rot_mat_t ALL_HI = '{SAT_HI, SAT_HI, SAT_HI, SAT_HI, SAT_HI,
                                  SAT_HI, SAT_HI, SAT_HI, SAT_HI};
  // Same, with z of the opposite sign to x and y.
  localparam rot_mat_t MIXED_SAT = '{SAT_HI, SAT_HI, SAT_LO, SAT_HI, SAT_HI,
                                     SAT_LO, SAT_LO, SAT_LO, SAT_HI};

  // One directed item; known rows carry their matrix, the others use the predictor.
  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               known;
    rot_mat_t           matrix;
  } dir_row_t;

  logic               clk;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  logic [15:0]        angle_deg_i;
  logic signed [15:0] axis_x_i;
  logic signed [15:0] axis_y_i;
  logic signed [15:0] axis_z_i;
  logic               valid_o;
  logic               stall_i;
  logic signed [15:0] m00_o, m01_o, m02_o;
  logic signed [15:0] m10_o, m11_o, m12_o;
  logic signed [15:0] m20_o, m21_o, m22_o;

  rot_mat_t matrix_q[$];
  dir_row_t dir_tbl[N_DIRECTED];
  int       fail_cnt;
  int       items_in;
  int       matrices_seen;
  int       cycle_cnt;
  int       send_idle_pct;
  bit       quiet;

  axis_angle_rotation_matrix #(
    .CORDIC_STAGES(STAGES)
  ) u_dut (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .angle_deg_i(angle_deg_i),
    .axis_x_i(axis_x_i),
    .axis_y_i(axis_y_i),
    .axis_z_i(axis_z_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .m00_o(m00_o),
    .m01_o(m01_o),
    .m02_o(m02_o),
    .m10_o(m10_o),
    .m11_o(m11_o),
    .m12_o(m12_o),
    .m20_o(m20_o),
    .m21_o(m21_o),
    .m22_o(m22_o)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Arctangent of 2^-i in Q30 for each CORDIC step.
  function automatic longint arctan_step_q30(input int i);
    longint a;
    case (i)
      0:       a = 843314856;
      1:       a = 497837829;
      2:       a = 263043836;
      3:       a = 133525158;
      4:       a = 67021686;
      5:       a = 33543515;
      6:       a = 16775850;
      7:       a = 8388437;
      8:       a = 4194282;
      9:       a = 2097149;
      10:      a = 1048575;
      11:      a = 524287;
      12:      a = 262143;
      13:      a = 131071;
      14:      a = 65535;
      15:      a = 32767;
      16:      a = 16383;
      17:      a = 8191;
      18:      a = 4095;
      19:      a = 2047;
      20:      a = 1023;
      21:      a = 511;
      22:      a = 255;
      default: a = 127;
    endcase
    return a;
  endfunction

  // Rounds a Q44 sum half up to Q14 and clamps it to 16 bits.
  function automatic logic [15:0] q44_to_q14_sat(input longint sum);
    longint v;
    v = (sum + 64'sd536870912) >>> 30;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Predicts the rotation matrix of one angle and axis.
  function automatic rot_mat_t rodrigues_predict(input logic [15:0] ang,
                                                 input logic signed [15:0] ax,
                                                 input logic signed [15:0] ay,
                                                 input logic signed [15:0] az);
    longint   u, quad, rem, cx, cy, cz, dx, dy, cq, sq;
    longint   c, s, t, xs, ys, zs, diag, txy, txz, tyz, sx, sy, sz;
    rot_mat_t m;
    u = ang;
    if (u >= TURN_UNITS) u = u - TURN_UNITS;
    quad = u / QUARTER_UNITS;
    rem  = u % QUARTER_UNITS;
    cz = (rem * UNIT_RAD_Q38 + 128) >>> 8;
    cx = CORDIC_K_Q30;
    cy = 0;
    // Rotation-mode CORDIC inside the first quadrant; shifts round toward minus infinity.
    for (int i = 0; i < STAGES && i < ARCTAN_ROWS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - arctan_step_q30(i);
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + arctan_step_q30(i);
      end
    end
    // Fold the quadrant back in by swapping and negating.
    case (quad)
      0: begin
        cq = cx;
        sq = cy;
      end
      1: begin
        cq = -cy;
        sq = cx;
      end
      2: begin
        cq = -cx;
        sq = -cy;
      end
      default: begin
        cq = cy;
        sq = -cx;
      end
    endcase
    c = (cq + 64'sd8192) >>> 14;
    s = (sq + 64'sd8192) >>> 14;
    t = 65536 - c;
    xs = ax;
    ys = ay;
    zs = az;
    // Exact products in Q44, one rounding per entry.
    diag = c * 268435456;
    txy  = t * xs * ys;
    txz  = t * xs * zs;
    tyz  = t * ys * zs;
    sx   = s * xs * 16384;
    sy   = s * ys * 16384;
    sz   = s * zs * 16384;
    m[0] = q44_to_q14_sat(t * xs * xs + diag);
    m[1] = q44_to_q14_sat(txy - sz);
    m[2] = q44_to_q14_sat(txz + sy);
    m[3] = q44_to_q14_sat(txy + sz);
    m[4] = q44_to_q14_sat(t * ys * ys + diag);
    m[5] = q44_to_q14_sat(tyz - sx);
    m[6] = q44_to_q14_sat(txz - sy);
    m[7] = q44_to_q14_sat(tyz + sx);
    m[8] = q44_to_q14_sat(t * zs * zs + diag);
    return m;
  endfunction

  // Offers one item after an optional idle burst and records its expected matrix.
  task automatic offer_item(input logic [15:0] ang, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z,
                            input logic known, input rot_mat_t fixed);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 3);
    repeat (gap) begin
      @(negedge clk);
      valid_i <= 1'b0;
    end
    @(negedge clk);
    valid_i     <= 1'b1;
    angle_deg_i <= ang;
    axis_x_i    <= x;
    axis_y_i    <= y;
    axis_z_i    <= z;
    do @(posedge clk); while (stall_o);
    matrix_q.push_back(known ? fixed : rodrigues_predict(ang, x, y, z));
    items_in++;
  endtask

  // Picks one axis component for the random part.
  function automatic logic signed [15:0] pick_component(input int mode);
    logic signed [15:0] v;
    case (mode)
      0: v = 16'($urandom_range(0, 32768) - 16384);
      1: v = 16'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       v = -16'sd32768;
          1:       v = -16'sd16384;
          2:       v = 16'sd0;
          3:       v = 16'sd16384;
          default: v = 16'sd32767;
        endcase
      end
    endcase
    return v;
  endfunction

  // Random angle: mostly uniform, some near quadrant edges, small or past a turn.
  function automatic logic [15:0] pick_angle();
    int a;
    case ($urandom_range(0, 9))
      6, 7: begin
        a = int'($urandom_range(0, 5) * QUARTER_UNITS + $urandom_range(0, 6) - 3);
        if (a < 0) a = 0;
      end
      8:       a = $urandom_range(0, 255);
      9:       a = $urandom_range(TURN_UNITS, 65535);
      default: a = $urandom_range(0, 65535);
    endcase
    return a[15:0];
  endfunction

  // Result side: random stall bursts, long hold-offs, and none in the final stretch.
  initial begin
    int hold_left;
    int burst_left;
    int recv_idle_pct;
    int next_hold_mark;
    int window;
    hold_left      = 0;
    burst_left     = 0;
    recv_idle_pct  = 10;
    next_hold_mark = 300;
    window         = 0;
    stall_i        = 1'b0;
    forever begin
      @(negedge clk);
      window++;
      if (window == 128) begin
        window = 0;
        case ($urandom_range(0, 2))
          0:       recv_idle_pct = 0;
          1:       recv_idle_pct = 10;
          default: recv_idle_pct = 30;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        stall_i <= 1'b1;
      end else if (!quiet && rst_ni && matrices_seen >= next_hold_mark) begin
        // Hold off long enough for the whole pipeline to fill and push back.
        hold_left      = HOLD_CYCLES - 1;
        next_hold_mark = next_hold_mark + 1000;
        stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
        burst_left = $urandom_range(1, 3) - 1;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // Compares each accepted matrix with the oldest expectation.
  always @(posedge clk) begin
    rot_mat_t got;
    rot_mat_t want;
    if (rst_ni && valid_o && !stall_i) begin
      got = '{m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
      matrices_seen++;
      if (matrix_q.size() == 0) begin
        $error("matrix arrived with no item waiting for it");
        fail_cnt++;
      end else begin
        want = matrix_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (got[k] !== want[k]) begin
            $error("m%0d%0d mismatch: expected %0d, actual %0d", k / 3, k % 3,
                   $signed(want[k]), $signed(got[k]));
            fail_cnt++;
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Reset, directed table, random items, drain and verdict.
  initial begin
    logic [15:0]        ang;
    logic signed [15:0] x, y, z;
    int                 mode;
    items_in      = 0;
    send_idle_pct = 10;
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    valid_i       = 1'b0;
    angle_deg_i   = '0;
    axis_x_i      = '0;
    axis_y_i      = '0;
    axis_z_i      = '0;

    // Cardinal axes at quadrant edges, wrap past a full turn, zero and oversized axes, diagonals.
    dir_tbl = '{
      '{16'd0,     16'sd0,      16'sd0,      16'sd16384,  1'b0, '0},
      '{16'd0,     16'sd16384,  16'sd0,      16'sd0,      1'b0, '0},
      '{16'd1,     16'sd0,      -16'sd16384, 16'sd0,      1'b0, '0},
      '{16'd5760,  16'sd9459,   16'sd9459,   16'sd9459,   1'b0, '0},
      '{16'd11519, 16'sd0,      16'sd0,      16'sd16384,  1'b0, '0},
      '{16'd11520, 16'sd0,      16'sd0,      16'sd16384,  1'b0, '0},
      '{16'd11521, 16'sd16384,  16'sd0,      16'sd0,      1'b0, '0},
      '{16'd23039, 16'sd0,      16'sd16384,  16'sd0,      1'b0, '0},
      '{16'd23040, 16'sd0,      16'sd16384,  16'sd0,      1'b0, '0},
      '{16'd34559, -16'sd16384, 16'sd0,      16'sd0,      1'b0, '0},
      '{16'd34560, 16'sd16384,  16'sd0,      16'sd0,      1'b0, '0},
      '{16'd46079, 16'sd0,      16'sd0,      -16'sd16384, 1'b0, '0},
      '{16'd46080, 16'sd0,      16'sd0,      16'sd16384,  1'b0, '0},
      '{16'd46081, 16'sd0,      16'sd16384,  16'sd0,      1'b0, '0},
      '{16'd65535, -16'sd16384, 16'sd0,      16'sd0,      1'b0, '0},
      '{16'd11520, 16'sd0,      16'sd0,      16'sd0,      1'b0, '0},
      '{16'd11520, 16'sd16384,  16'sd16384,  16'sd16384,  1'b0, '0},
      '{16'd11520, -16'sd32768, 16'sd32767,  -16'sd32768, 1'b0, '0},
      '{16'd23040, 16'sd32767,  16'sd32767,  16'sd32767,  1'b1, ALL_HI},
      '{16'd23040, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, ALL_HI},
      '{16'd23040, -16'sd32768, -16'sd32768, 16'sd32767,  1'b1, MIXED_SAT},
      '{16'd17280, 16'sd11585,  -16'sd11585, 16'sd0,      1'b0, '0},
      '{16'd57600, 16'sd0,      16'sd0,      -16'sd16384, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_item(dir_tbl[i].angle, dir_tbl[i].ax, dir_tbl[i].ay, dir_tbl[i].az,
                 dir_tbl[i].known, dir_tbl[i].matrix);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      // Sender idle density changes every 128 items; the last stretch runs flat out.
      if (i % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       send_idle_pct = 0;
          1:       send_idle_pct = 10;
          default: send_idle_pct = 30;
        endcase
      end
      if (i == N_RANDOM - N_QUIET) quiet = 1'b1;
      // Once, let the whole pipeline drain before offering more.
      if (i == 950) begin
        @(negedge clk);
        valid_i <= 1'b0;
        while (matrix_q.size() != 0) @(posedge clk);
      end
      ang = pick_angle();
      case ($urandom_range(0, 9))
        6, 7: begin
          x = 16'sd0;
          y = 16'sd0;
          z = 16'sd0;
          case ($urandom_range(0, 2))
            0:       x = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            1:       y = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: z = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
          endcase
        end
        default: begin
          mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
          x = pick_component(mode);
          y = pick_component(mode);
          z = pick_component(mode);
        end
      endcase
      offer_item(ang, x, y, z, 1'b0, '0);
    end

    @(negedge clk);
    valid_i <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);

    $display("Sent %0d angle/axis items (%0d directed), checked %0d matrices entry by entry.",
             items_in, N_DIRECTED, matrices_seen);
    $display("Runs included a drained pipeline and back-pressure holds of %0d cycles.",
             HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/aar_pkg.sv
src/aar_angle.sv
src/aar_cordic_stage.sv
src/aar_matrix.sv
src/axis_angle_rotation_matrix.sv
test/testbench.sv
